### hdl/vpr_pkg.sv
package vpr_pkg;

    // Component width of the source, direction and result vectors (signed).
    localparam int COMP_WIDTH = 32;
    localparam int CW = COMP_WIDTH;

    // Width of a single component product and of the squared norm M.
    localparam int PW = 2 * CW;
    localparam int MW = 2 * CW;
    // Dot product D, a sum of three signed products.
    localparam int DW = 2 * CW + 2;
    // Widths of B*D and A*M after recombining the partial products.
    localparam int BDW = CW + DW;
    localparam int AMW = CW + MW + 1;
    // Numerator, dividend 2|N|+M, divisor 2M and quotient.
    localparam int NW = 3 * CW + 4;
    localparam int XW = NW + 2;
    localparam int YW = MW + 1;
    localparam int QW = CW;

    // Pipeline depth: two dot stages, six numerator stages, quotient bits, output.
    localparam int LAT = 2 + 6 + QW + 1;

    // Mode codes.
    localparam logic [1:0] MODE_PROJ = 2'd0;
    localparam logic [1:0] MODE_PERP = 2'd1;
    localparam logic [1:0] MODE_REFL = 2'd2;

    typedef logic signed [CW-1:0] comp_t;

    typedef struct packed {
        logic [1:0] mode;
        comp_t      src_x;
        comp_t      src_y;
        comp_t      src_z;
        comp_t      dir_x;
        comp_t      dir_y;
        comp_t      dir_z;
    } req_t;

    typedef struct packed {
        comp_t res_x;
        comp_t res_y;
        comp_t res_z;
        logic  degenerate;
        logic  saturated;
    } rsp_t;

    // State of one component as it moves through the divider stages.
    typedef struct packed {
        logic [YW-1:0] rem;
        logic [QW-1:0] xl;
        logic [QW-1:0] q;
        logic [YW-1:0] y;
        logic          big;
        logic          neg;
        logic          degen;
        logic          proj;
        comp_t         a;
    } div_t;

    // Finished component.
    typedef struct packed {
        comp_t res;
        logic  sat;
        logic  degen;
    } comp_res_t;

endpackage

### hdl/vpr_dot.sv
module vpr_dot (
    input  logic                   clk,
    input  logic                   adv,
    input  vpr_pkg::req_t          req_data,
    output logic signed [vpr_pkg::DW-1:0] d,
    output logic [vpr_pkg::MW-1:0] m,
    output vpr_pkg::comp_t         a [3],
    output vpr_pkg::comp_t         b [3],
    output logic [1:0]             mode
);

    logic signed [vpr_pkg::PW-1:0] ab_reg [3];
    logic signed [vpr_pkg::PW-1:0] bb_reg [3];
    vpr_pkg::comp_t                a1_reg [3];
    vpr_pkg::comp_t                b1_reg [3];
    logic [1:0]                    mode1_reg;

    logic signed [vpr_pkg::DW-1:0] d_reg;
    logic [vpr_pkg::MW-1:0]        m_reg;
    vpr_pkg::comp_t                a2_reg [3];
    vpr_pkg::comp_t                b2_reg [3];
    logic [1:0]                    mode2_reg;

    vpr_pkg::comp_t                src [3];
    vpr_pkg::comp_t                dir [3];

    always_comb
    begin
        src[0] = req_data.src_x;
        src[1] = req_data.src_y;
        src[2] = req_data.src_z;
        dir[0] = req_data.dir_x;
        dir[1] = req_data.dir_y;
        dir[2] = req_data.dir_z;
    end

    // First stage: the six component products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= src[i] * dir[i];
                bb_reg[i] <= dir[i] * dir[i];
                a1_reg[i] <= src[i];
                b1_reg[i] <= dir[i];
            end
            mode1_reg <= req_data.mode;
        end
    end

    // Second stage: dot product and squared norm of the direction.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= vpr_pkg::DW'(ab_reg[0]) + vpr_pkg::DW'(ab_reg[1])
                     + vpr_pkg::DW'(ab_reg[2]);
            m_reg <= $unsigned(bb_reg[0]) + $unsigned(bb_reg[1]) + $unsigned(bb_reg[2]);
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    assign d    = d_reg;
    assign m    = m_reg;
    assign a    = a2_reg;
    assign b    = b2_reg;
    assign mode = mode2_reg;

endmodule

### hdl/vpr_numer.sv
module vpr_numer (
    input  logic                          clk,
    input  logic                          adv,
    input  vpr_pkg::comp_t                a,
    input  vpr_pkg::comp_t                b,
    input  logic signed [vpr_pkg::DW-1:0] d,
    input  logic [vpr_pkg::MW-1:0]        m,
    input  logic [1:0]                    mode,
    output vpr_pkg::div_t                 dout
);

    localparam int CW = vpr_pkg::CW;

    // Stage 3: partial products.
    logic signed [2*CW:0]        bdlo_reg;
    logic signed [2*CW+1:0]      bdhi_reg;
    logic signed [2*CW:0]        amlo_reg;
    logic signed [2*CW:0]        amhi_reg;
    logic [vpr_pkg::MW-1:0]      m3_reg;
    logic [1:0]                  mode3_reg;
    logic                        degen3_reg;
    vpr_pkg::comp_t              a3_reg;

    // Stage 4: full products.
    logic signed [vpr_pkg::BDW-1:0] bd_reg;
    logic signed [vpr_pkg::AMW-1:0] am_reg;
    logic [vpr_pkg::MW-1:0]      m4_reg;
    logic [1:0]                  mode4_reg;
    logic                        degen4_reg;
    vpr_pkg::comp_t              a4_reg;

    // Stage 5: signed numerator.
    logic signed [vpr_pkg::NW-1:0] n_reg;
    logic signed [vpr_pkg::NW-1:0] n_next;
    logic [vpr_pkg::MW-1:0]      m5_reg;
    logic                        proj5_reg;
    logic                        degen5_reg;
    vpr_pkg::comp_t              a5_reg;

    // Stage 6: magnitude and sign.
    logic [vpr_pkg::NW-1:0]      nabs_reg;
    logic                        neg6_reg;
    logic [vpr_pkg::MW-1:0]      m6_reg;
    logic                        proj6_reg;
    logic                        degen6_reg;
    vpr_pkg::comp_t              a6_reg;

    // Stage 7: dividend and divisor for rounding to nearest.
    logic [vpr_pkg::XW-1:0]      x_reg;
    logic [vpr_pkg::YW-1:0]      y_reg;
    logic                        neg7_reg;
    logic                        proj7_reg;
    logic                        degen7_reg;
    vpr_pkg::comp_t              a7_reg;

    // Stage 8: range check and divider setup.
    vpr_pkg::div_t               dv_reg;
    vpr_pkg::div_t               dv_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bdlo_reg   <= b * $signed({1'b0, d[CW-1:0]});
            bdhi_reg   <= b * $signed(d[vpr_pkg::DW-1:CW]);
            amlo_reg   <= a * $signed({1'b0, m[CW-1:0]});
            amhi_reg   <= a * $signed({1'b0, m[vpr_pkg::MW-1:CW]});
            m3_reg     <= m;
            mode3_reg  <= mode;
            degen3_reg <= (m == '0);
            a3_reg     <= a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bd_reg     <= (vpr_pkg::BDW'(bdhi_reg) <<< CW) + vpr_pkg::BDW'(bdlo_reg);
            am_reg     <= (vpr_pkg::AMW'(amhi_reg) <<< CW) + vpr_pkg::AMW'(amlo_reg);
            m4_reg     <= m3_reg;
            mode4_reg  <= mode3_reg;
            degen4_reg <= degen3_reg;
            a4_reg     <= a3_reg;
        end
    end

    // Numerator by mode; the unused code reflects like the reflection mode.
    always_comb
    begin
        if (mode4_reg == vpr_pkg::MODE_PROJ)
        begin
            n_next = vpr_pkg::NW'(bd_reg);
        end
        else if (mode4_reg == vpr_pkg::MODE_PERP)
        begin
            n_next = vpr_pkg::NW'(am_reg) - vpr_pkg::NW'(bd_reg);
        end
        else
        begin
            n_next = vpr_pkg::NW'(am_reg) - (vpr_pkg::NW'(bd_reg) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg      <= n_next;
            m5_reg     <= m4_reg;
            proj5_reg  <= (mode4_reg == vpr_pkg::MODE_PROJ);
            degen5_reg <= degen4_reg;
            a5_reg     <= a4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nabs_reg   <= n_reg[vpr_pkg::NW-1] ? $unsigned(-n_reg) : $unsigned(n_reg);
            neg6_reg   <= n_reg[vpr_pkg::NW-1];
            m6_reg     <= m5_reg;
            proj6_reg  <= proj5_reg;
            degen6_reg <= degen5_reg;
            a6_reg     <= a5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg      <= (vpr_pkg::XW'(nabs_reg) << 1) + vpr_pkg::XW'(m6_reg);
            y_reg      <= {m6_reg, 1'b0};
            neg7_reg   <= neg6_reg;
            proj7_reg  <= proj6_reg;
            degen7_reg <= degen6_reg;
            a7_reg     <= a6_reg;
        end
    end

    // A quotient that does not fit in QW bits is flagged here and clamped later.
    always_comb
    begin
        dv_next.big   = x_reg >= (vpr_pkg::XW'(y_reg) << vpr_pkg::QW);
        dv_next.rem   = x_reg[vpr_pkg::QW+vpr_pkg::YW-1:vpr_pkg::QW];
        dv_next.xl    = x_reg[vpr_pkg::QW-1:0];
        dv_next.q     = '0;
        dv_next.y     = y_reg;
        dv_next.neg   = neg7_reg;
        dv_next.degen = degen7_reg;
        dv_next.proj  = proj7_reg;
        dv_next.a     = a7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg <= dv_next;
        end
    end

    assign dout = dv_reg;

endmodule

### hdl/vpr_div.sv
module vpr_div (
    input  logic               clk,
    input  logic               adv,
    input  vpr_pkg::div_t      din,
    output vpr_pkg::comp_res_t dout
);

    localparam int QW = vpr_pkg::QW;
    localparam int YW = vpr_pkg::YW;
    localparam int CW = vpr_pkg::CW;

    // One restoring quotient bit per stage.
    function automatic vpr_pkg::div_t div_step(input vpr_pkg::div_t s);
        vpr_pkg::div_t r;
        logic [YW:0]   rs;
        logic          ge;
        r    = s;
        rs   = {s.rem, s.xl[QW-1]};
        ge   = (rs >= {1'b0, s.y});
        r.rem = ge ? YW'(rs - {1'b0, s.y}) : rs[YW-1:0];
        r.xl  = {s.xl[QW-2:0], 1'b0};
        r.q   = {s.q[QW-2:0], ge};
        return r;
    endfunction

    vpr_pkg::div_t      st_reg [QW];
    vpr_pkg::comp_res_t res_reg;
    vpr_pkg::comp_res_t res_next;
    logic [QW-1:0]      q;

    // Divider stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= div_step(din);
            for (int j = 1; j < QW; j++)
            begin
                st_reg[j] <= div_step(st_reg[j-1]);
            end
        end
    end

    // Sign, clamp to the component range, and the zero-direction case.
    always_comb
    begin
        q = st_reg[QW-1].q;
        res_next.degen = st_reg[QW-1].degen;
        res_next.sat   = 1'b0;
        if (st_reg[QW-1].degen)
        begin
            res_next.res = st_reg[QW-1].proj ? '0 : st_reg[QW-1].a;
        end
        else if (!st_reg[QW-1].neg)
        begin
            if (st_reg[QW-1].big || q[CW-1])
            begin
                res_next.res = {1'b0, {(CW-1){1'b1}}};
                res_next.sat = 1'b1;
            end
            else
            begin
                res_next.res = $signed(CW'(q));
            end
        end
        else
        begin
            if (st_reg[QW-1].big || (q[CW-1] && (|q[CW-2:0])))
            begin
                res_next.res = {1'b1, {(CW-1){1'b0}}};
                res_next.sat = 1'b1;
            end
            else
            begin
                res_next.res = $signed(CW'(-q));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign dout = res_reg;

endmodule

### hdl/vector_project_perpendicular_reflect.sv
// A request passes through 41 register stages on its way to the response
// (2 dot-product, 6 numerator, 32 divider with one quotient bit each, 1 output).
// Throughput: one request per cycle; the whole pipeline holds while a response waits.
// Reset: rst_n clears only the per-stage valid bits; datapath registers are not reset.
module vector_project_perpendicular_reflect (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  vpr_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output vpr_pkg::rsp_t rsp_data
);

    logic [vpr_pkg::LAT-1:0]       valid_reg;
    logic                          adv;

    logic signed [vpr_pkg::DW-1:0] d;
    logic [vpr_pkg::MW-1:0]        m;
    vpr_pkg::comp_t                a [3];
    vpr_pkg::comp_t                b [3];
    logic [1:0]                    mode;
    vpr_pkg::div_t                 dv [3];
    vpr_pkg::comp_res_t            cr [3];

    // The pipeline moves whenever the output stage is empty or being drained.
    assign adv       = !valid_reg[vpr_pkg::LAT-1] || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = valid_reg[vpr_pkg::LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[vpr_pkg::LAT-2:0], req_valid};
        end
    end

    vpr_dot u_dot (
        .clk      (clk),
        .adv      (adv),
        .req_data (req_data),
        .d        (d),
        .m        (m),
        .a        (a),
        .b        (b),
        .mode     (mode)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        vpr_numer u_numer (
            .clk  (clk),
            .adv  (adv),
            .a    (a[i]),
            .b    (b[i]),
            .d    (d),
            .m    (m),
            .mode (mode),
            .dout (dv[i])
        );

        vpr_div u_div (
            .clk  (clk),
            .adv  (adv),
            .din  (dv[i]),
            .dout (cr[i])
        );
    end

    // Assemble the response from the registered component results.
    always_comb
    begin
        rsp_data.res_x      = cr[0].res;
        rsp_data.res_y      = cr[1].res;
        rsp_data.res_z      = cr[2].res;
        rsp_data.degenerate = cr[0].degen | cr[1].degen | cr[2].degen;
        rsp_data.saturated  = cr[0].sat | cr[1].sat | cr[2].sat;
    end

endmodule

### hdl/vpr_checker.sv
module vpr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input vpr_pkg::rsp_t rsp_data
);

    // A stalled response keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // A zero direction never reports clamping.
    a_degen_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.degenerate |-> !rsp_data.saturated)
        else $error("degenerate response flagged saturated");

    // With no response pending the block takes requests.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty output");

    // A stalled output holds the whole pipeline.
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while output stalled");

    // No response is valid in the cycle that reset is released.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind vector_project_perpendicular_reflect vpr_checker u_vpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
